@@ rtl/mipb_pkg.sv @@
// Shared types and constants for the masked address ban table.
// Used by the controller and the top level; no dependencies of its own.
`default_nettype none

package mipb_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] now;
    logic [WORD_W-1:0] end_time;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] address;
    logic [KIND_W-1:0] kind;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] ban_end;
    logic              banned;
  } res_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [WORD_W-1:0] end_time;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] address;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

@@ rtl/mipb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module mipb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/mipb_ctrl.sv @@
// Sequencer for the ban table: walks the entry memory for lookup, insert
// and remove, and holds the entry count. Depends on mipb_pkg.
`default_nettype none

module mipb_ctrl
  import mipb_pkg::*;
#(
  parameter  int unsigned N      = TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W  = (N > 1) ? $clog2(N) : 1,
  localparam int unsigned CNT_W  = $clog2(N + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire item_t            item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output res_t                  res,
  output logic [IDX_W-1:0]      mem_raddr,
  input  wire logic [ENT_W-1:0] mem_rdata,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output logic [ENT_W-1:0]      mem_wdata
);

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t           state_r, state_nxt;
  item_t            item_r, item_nxt;
  res_t             res_r, res_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic [CNT_W-1:0] di_r;
  logic             dv_r;

  ent_t             rd;
  ent_t             item_ent;
  logic             issue;
  logic             lk_hit;
  logic             ins_hit;
  logic             last;
  logic             full;
  logic             pos_bad;
  logic [CMP_W-1:0] pos_w;
  logic [CNT_W-1:0] di_prev;

  assign rd       = ent_t'(mem_rdata);
  assign item_ent = '{end_time: item_r.end_time, mask: item_r.mask, address: item_r.address};
  assign issue    = (state_r == ST_SCAN) && (iss_r < cnt_r);
  assign lk_hit   = ((rd.address & rd.mask) == (item_r.address & rd.mask)) &&
                    ((rd.end_time == '0) || (item_r.now < rd.end_time));
  assign ins_hit  = (rd.address == item_r.address) && (rd.mask == item_r.mask);
  assign last     = (di_r == (cnt_r - CNT_W'(1)));
  assign full     = (cnt_r == CNT_W'(N));
  assign pos_w    = CMP_W'(item.position);
  assign pos_bad  = (item.position == '0) || (pos_w > CMP_W'(cnt_r));
  assign di_prev  = di_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      iss_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      iss_r   <= iss_nxt;
      dv_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    di_r   <= iss_r;
  end

  // Next state and datapath registers.
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    iss_nxt   = issue ? (iss_r + CNT_W'(1)) : iss_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = item;
          iss_nxt  = '0;
          res_nxt  = '{status: ST_DONE, ban_end: '0, banned: 1'b0};
          case (item.kind)
            KIND_LOOKUP: begin
              res_nxt.ban_end = WORD_W'(1);
              if ((item.address == '0) || (cnt_r == '0)) begin
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            KIND_INSERT: begin
              state_nxt = (cnt_r == '0) ? ST_WRITE : ST_SCAN;
            end
            KIND_REMOVE: begin
              if (pos_bad) begin
                res_nxt.status = ST_NOT_FOUND;
                state_nxt      = ST_RESP;
              end else if (pos_w == CMP_W'(cnt_r)) begin
                // Removing the tail entry needs no shifting.
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = ST_RESP;
              end else begin
                iss_nxt   = CNT_W'(item.position);
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (dv_r) begin
          case (item_r.kind)
            KIND_LOOKUP: begin
              if (lk_hit) begin
                res_nxt.banned  = 1'b1;
                res_nxt.ban_end = rd.end_time;
                state_nxt       = ST_RESP;
              end else if (last) begin
                state_nxt = ST_RESP;
              end
            end
            KIND_INSERT: begin
              if (ins_hit) begin
                state_nxt = ST_RESP;
              end else if (last) begin
                if (full) begin
                  res_nxt.status = ST_FULL;
                  state_nxt      = ST_RESP;
                end else begin
                  state_nxt = ST_WRITE;
                end
              end
            end
            KIND_REMOVE: begin
              if (last) begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = ST_RESP;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_WRITE: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = di_r[IDX_W-1:0];
    mem_wdata = item_ent;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        if (dv_r) begin
          if ((item_r.kind == KIND_INSERT) && ins_hit) begin
            // Same address and mask: rewrite the entry with the new end time.
            mem_we = 1'b1;
          end else if (item_r.kind == KIND_REMOVE) begin
            // Each entry read moves down one place to close the gap.
            mem_we    = 1'b1;
            mem_waddr = di_prev[IDX_W-1:0];
            mem_wdata = mem_rdata;
          end
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[IDX_W-1:0];
      end
      ST_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign mem_raddr = iss_r[IDX_W-1:0];
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r == $past(cnt_r) - CNT_W'(1))))
    else $error("entry count moved by more than one");

  a_cnt_at_resp: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (state_r == ST_RESP))
    else $error("entry count changed outside the end of an item");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_SCAN) || (state_r == ST_WRITE)))
    else $error("table written outside a scan or append");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (cnt_r < CNT_W'(N)))
    else $error("append into a full table");
`endif

endmodule

`default_nettype wire

@@ rtl/masked_ip_ban_table.sv @@
// Masked address ban table: lookup, insert or update, and remove by position.
// One item is in work at a time; the next is taken once the last result is in the output register.
// Reset clears the entry count and control state only.
// Depends on mipb_pkg, mipb_ram and mipb_ctrl.
`default_nettype none

module masked_ip_ban_table
  import mipb_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // kind[1:0], address[33:2], mask[65:34], end_time[97:66], now[129:98],
  // position[136:130], zero padding above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // banned[0], ban_end[32:1], status[34:33], zero padding above
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  item_t            item;
  res_t             res;
  res_t             out_res_r;
  logic             out_valid_r;
  logic             res_valid;
  logic             res_ready;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_rdata;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_we;

  assign item = item_t'(in_tdata[$bits(item_t)-1:0]);

  mipb_ctrl #(
    .N (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  mipb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: the sequencer can start on the next item while a
  // result still waits here for its transfer.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for masked_ip_ban_table: a scoreboard class predicts each result
// from its own copy of the ban table. Depends on mipb_pkg and the RTL of the block.

module tb_top;
  import mipb_pkg::*;

  localparam int unsigned DEPTH       = TABLE_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned SQUEEZE_LEN = 300;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Holds the expected ban table and the results still owed by the block.
  class ban_scoreboard;
    logic [WORD_W-1:0] addr_tab [DEPTH];
    logic [WORD_W-1:0] mask_tab [DEPTH];
    logic [WORD_W-1:0] end_tab [DEPTH];
    int unsigned used;
    res_t expected_q [$];
    int unsigned errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void note_item(item_t it);
      res_t r;
      bit hit;
      int i;
      r = '0;
      r.status = ST_DONE;
      hit = 1'b0;
      case (it.kind)
        KIND_LOOKUP: begin
          r.ban_end = 32'd1;
          // A zero client address never matches, even a ban with a zero mask.
          if (it.address != '0) begin
            for (i = 0; i < used; i++) begin
              if (!hit && (addr_tab[i] & mask_tab[i]) == (it.address & mask_tab[i]) &&
                  (end_tab[i] == '0 || it.now < end_tab[i])) begin
                hit = 1'b1;
                r.banned = 1'b1;
                r.ban_end = end_tab[i];
              end
            end
          end
        end
        KIND_INSERT: begin
          for (i = 0; i < used; i++) begin
            if (!hit && addr_tab[i] == it.address && mask_tab[i] == it.mask) begin
              hit = 1'b1;
              end_tab[i] = it.end_time;
            end
          end
          if (!hit) begin
            if (used >= DEPTH) begin
              r.status = ST_FULL;
            end else begin
              addr_tab[used] = it.address;
              mask_tab[used] = it.mask;
              end_tab[used] = it.end_time;
              used++;
            end
          end
        end
        KIND_REMOVE: begin
          if (it.position == '0 || it.position > used) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (i = int'(it.position) - 1; i + 1 < used; i++) begin
              addr_tab[i] = addr_tab[i + 1];
              mask_tab[i] = mask_tab[i + 1];
              end_tab[i] = end_tab[i + 1];
            end
            used--;
          end
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: banned %0d ban_end %h status %0d",
                 $time, got.banned, got.ban_end, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.banned !== want.banned) begin
        errors++;
        $display("%0t: banned expected %0d actual %0d", $time, want.banned, got.banned);
      end
      if (got.ban_end !== want.ban_end) begin
        errors++;
        $display("%0t: ban_end expected %h actual %h", $time, want.ban_end, got.ban_end);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  ban_scoreboard board = new();
  int unsigned accepted_items = 0;
  int unsigned quiet_cycles = 0;
  logic [WORD_W-1:0] host_pool [16];

  masked_ip_ban_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Neither side idles while this window of transfers is in progress.
  function automatic bit calm();
    return accepted_items >= 400 && accepted_items < 560;
  endfunction

  function automatic item_t make_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] address,
                                      logic [WORD_W-1:0] mask, logic [WORD_W-1:0] end_time,
                                      logic [WORD_W-1:0] now, logic [POS_W-1:0] position);
    item_t it;
    it.kind = kind;
    it.address = address;
    it.mask = mask;
    it.end_time = end_time;
    it.now = now;
    it.position = position;
    return it;
  endfunction

  function automatic logic [WORD_W-1:0] pick_mask();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'hFFFF_FFFF;
      3, 4:    return 32'hFFFF_FF00;
      5:       return 32'hFFFF_0000;
      6:       return 32'hFF00_0000;
      7:       return ($urandom_range(0, 7) == 0) ? 32'h0 : 32'hFFFF_FFF0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_end();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 32'h0;
    if (roll < 20) return 32'hFFFF_FFFF;
    return $urandom_range(1, 2000);
  endfunction

  function automatic logic [WORD_W-1:0] pick_now();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 32'h0;
    if (roll < 15) return 32'hFFFF_FFFF;
    if (roll < 20) return $urandom;
    return $urandom_range(0, 2200);
  endfunction

  // The mix drifts between filling the table, probing it and emptying it.
  function automatic item_t random_item(int unsigned phase);
    item_t it;
    int unsigned roll, ins_pct, rem_pct, k, top;
    it = make_item(KIND_LOOKUP, $urandom, $urandom, $urandom, $urandom,
                   POS_W'($urandom_range(0, DEPTH)));
    case (phase)
      0:       begin ins_pct = 67; rem_pct = 3;  end
      1:       begin ins_pct = 30; rem_pct = 20; end
      default: begin ins_pct = 15; rem_pct = 40; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      it.kind = KIND_INSERT;
      if ($urandom_range(0, 1) == 0) it.address = host_pool[$urandom_range(0, 15)];
      it.mask = pick_mask();
      it.end_time = pick_end();
    end else if (roll >= 100 - rem_pct) begin
      it.kind = KIND_REMOVE;
      top = (board.used + 1 > DEPTH) ? DEPTH : board.used + 1;
      if ($urandom_range(0, 9) < 8) it.position = POS_W'($urandom_range(0, top));
    end else begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        it.address = '0;
      end else if (roll >= 3 && roll <= 6 && board.used > 0) begin
        k = $urandom_range(0, board.used - 1);
        it.address = board.addr_tab[k] ^ ($urandom & ~board.mask_tab[k]);
      end else if (roll >= 3) begin
        it.address = host_pool[$urandom_range(0, 15)] ^ ($urandom & 32'hFF);
      end
      it.now = pick_now();
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    while (!calm() && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W - $bits(item_t)){1'b0}}, it};
    do @(posedge clk); while (!in_tready);
    board.note_item(it);
    accepted_items++;
  endtask

  // Result side: checks each transfer, stalls at random and once holds off for a long stretch.
  initial begin
    int unsigned hold;
    bit squeezed;
    hold = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        board.check_result(res_t'(out_tdata[$bits(res_t)-1:0]));
      end
      if (!squeezed && accepted_items >= 800) begin
        squeezed = 1'b1;
        hold = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm() || $urandom_range(0, 99) >= 31;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    for (n = 0; n < 16; n++) host_pool[n] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, zero and all-ones addresses, removes that find nothing.
    send_item(make_item(KIND_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 7'd64));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd0));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd1));
    // Permanent ban, latest possible end, timed ban and a catch-all with a zero mask.
    send_item(make_item(KIND_INSERT, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0, 32'h0, 7'd0));
    send_item(make_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h0, 7'd0));
    send_item(make_item(KIND_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'd1000, 32'h0, 7'd0));
    send_item(make_item(KIND_INSERT, 32'h0, 32'h0, 32'd500, 32'h0, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'hC0A8_01FF, 32'h0, 32'h0, 32'hFFFF_FFFF, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 32'd999, 7'd0));
    // Expired matches are skipped and the walk carries on.
    send_item(make_item(KIND_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 32'd1000, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 32'd499, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFE, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 7'd0));
    send_item(make_item(KIND_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'd2000, 32'h0, 7'd0));
    send_item(make_item(KIND_LOOKUP, 32'h0A00_0001, 32'h0, 32'h0, 32'd1500, 7'd0));
    send_item(make_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 7'd64));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd64));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd5));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd2));
    send_item(make_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 7'd0));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd3));
    send_item(make_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd1));
    send_item(make_item(KIND_LOOKUP, 32'hC0A8_0105, 32'h0, 32'h0, 32'h0, 7'd0));

    for (n = 0; n < RANDOM_ITEMS; n++) send_item(random_item((n / 150) % 3));
    in_tvalid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
